FILE: rtl/core/tws_pkg.sv
package tws_pkg;

   // command codes carried on the request tuser
   typedef enum logic [1:0] {
      OP_ADVANCE = 2'd0,
      OP_WRITE   = 2'd1,
      OP_READ    = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2
   } mode_type;

   localparam int PHASE_W = 6;

   // clock phases of a write, of a read and of the control byte
   localparam logic [PHASE_W-1:0] WRITE_PHASES = 6'd32;
   localparam logic [PHASE_W-1:0] READ_PHASES  = 6'd30;
   localparam logic [PHASE_W-1:0] CTRL_PHASES  = 6'd16;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_count;
      logic [15:0]        transmit_shift;
      logic [7:0]         receive_shift;
      mode_type           transfer_mode;
   } state_type;

   // laid out so that it is the result tdata word, enable_pin in bit 0
   typedef struct packed {
      logic [1:0] pad;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_result;
      logic       data_drive;
      logic       data_out;
      logic       clock_pin;
      logic       enable_pin;
   } result_type;

endpackage

FILE: rtl/core/tws_step.sv
module tws_step (
   input  tws_pkg::state_type  cur_state,
   input  logic [1:0]          op,
   input  logic [7:0]          control_byte,
   input  logic [7:0]          write_byte,
   input  logic                data_in,
   output tws_pkg::state_type  nxt_state,
   output tws_pkg::result_type result
);

   logic [tws_pkg::PHASE_W-1:0] limit;
   logic [7:0]                  rx_sampled;
   logic                        done;
   logic [7:0]                  read_byte;
   logic                        drive;
   logic                        busy;

   always_comb begin
      nxt_state  = cur_state;
      done       = 1'b0;
      read_byte  = 8'd0;
      rx_sampled = cur_state.receive_shift;
      limit      = (cur_state.transfer_mode == tws_pkg::MODE_WRITE) ?
                   tws_pkg::WRITE_PHASES : tws_pkg::READ_PHASES;

      if (cur_state.transfer_mode == tws_pkg::MODE_IDLE) begin
         case (tws_pkg::op_type'(op)) inside
            tws_pkg::OP_WRITE, tws_pkg::OP_READ: begin
               nxt_state.transfer_mode  = (tws_pkg::op_type'(op) == tws_pkg::OP_WRITE) ?
                                          tws_pkg::MODE_WRITE : tws_pkg::MODE_READ;
               nxt_state.phase_count    = '0;
               nxt_state.transmit_shift = {write_byte, control_byte};
               nxt_state.receive_shift  = 8'd0;
            end
            default: begin
               nxt_state = cur_state;
            end
         endcase
      end else begin
         // sample while the clock is low after a fall in the data phase
         if (cur_state.transfer_mode == tws_pkg::MODE_READ &&
             cur_state.phase_count >= tws_pkg::CTRL_PHASES &&
             !cur_state.phase_count[0]) begin
            rx_sampled = {data_in, cur_state.receive_shift[7:1]};
         end
         nxt_state.receive_shift = rx_sampled;

         if (cur_state.phase_count >= limit) begin
            done = 1'b1;
            if (cur_state.transfer_mode == tws_pkg::MODE_READ) begin
               read_byte = rx_sampled;
            end
            nxt_state.transfer_mode = tws_pkg::MODE_IDLE;
            nxt_state.phase_count   = '0;
         end else begin
            // next bit is presented on the falling phase
            if (cur_state.phase_count[0]) begin
               nxt_state.transmit_shift = {1'b0, cur_state.transmit_shift[15:1]};
            end
            nxt_state.phase_count = cur_state.phase_count + 1'b1;
         end
      end
   end

   assign busy  = (nxt_state.transfer_mode != tws_pkg::MODE_IDLE);
   assign drive = (nxt_state.transfer_mode == tws_pkg::MODE_WRITE) ||
                  (nxt_state.transfer_mode == tws_pkg::MODE_READ &&
                   nxt_state.phase_count < tws_pkg::CTRL_PHASES);

   always_comb begin
      result             = '0;
      result.enable_pin  = busy;
      result.clock_pin   = busy & nxt_state.phase_count[0];
      result.data_out    = drive & nxt_state.transmit_shift[0];
      result.data_drive  = drive;
      result.read_result = read_byte;
      result.done_res    = done;
      result.busy_res    = busy;
   end

endmodule

FILE: rtl/core/three_wire_serial_master_unit.sv
// three-wire serial master (enable, clock, bidirectional data), one pin phase per item
//
// request channel: each item is one tick; tuser holds the command (advance, start
// write, start read), tdata holds the control byte, the write byte and the level
// seen on the data line during that tick. a start while a transfer runs is ignored
// and only advances it.
// result channel: one item per request item with the pin levels after the tick,
// the read byte and done on the finishing tick, and busy.
//
// an item is registered at the input, runs through the tick logic and lands in the
// result register. throughput: one item per cycle unless rsp_tready stalls it; the
// tick logic is a few shifts and a 6-bit count.
//
// reset: synchronous, active high; the engine returns to idle with all counters and
// shift registers cleared and both channels empty.
// stall: when rsp_tready is low the result register holds, the input register fills
// and then req_tready drops; no item is lost or advanced while stalled.
module three_wire_serial_master_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // op
   input  logic [23:0] req_tdata,   // control_byte[7:0], write_byte[15:8], data_in[16], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // enable_pin, clock_pin, data_out, data_drive,
                                    // read_result[11:4], done_res, busy_res, zero
);

   // input register
   logic                in_valid_ff, in_valid_in;
   logic [1:0]          in_op_ff;
   logic [7:0]          in_ctrl_ff;
   logic [7:0]          in_wr_ff;
   logic                in_din_ff;

   // transfer state and result register
   tws_pkg::state_type  state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   tws_pkg::result_type out_data_ff;

   tws_pkg::result_type step_result;
   logic                advance;
   logic                req_take;

   // the input item moves on when the result register is free or being drained
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   tws_step u_step (
      .cur_state    (state_ff),
      .op           (in_op_ff),
      .control_byte (in_ctrl_ff),
      .write_byte   (in_wr_ff),
      .data_in      (in_din_ff),
      .nxt_state    (state_in),
      .result       (step_result)
   );

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // the tick takes effect only when its result is registered
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_tuser;
         in_ctrl_ff <= req_tdata[7:0];
         in_wr_ff   <= req_tdata[15:8];
         in_din_ff  <= req_tdata[16];
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
